>>> hw/rtl/fan_tachometer_rpm_core_assert.svh
// Assertion macros for the fan tachometer RTL.
`ifndef FAN_TACHOMETER_RPM_CORE_ASSERT_SVH
`define FAN_TACHOMETER_RPM_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FANTACH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FANTACH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fantach_pkg.sv
// Types and constants shared by the fan tachometer RTL.
`timescale 1ns / 1ps
package fantach_pkg;

  localparam int unsigned TS_IN_W   = 32;  // timestamp port width
  localparam int unsigned CLK_W     = 32;  // clock_hz register width
  localparam int unsigned TMO_W     = 8;   // timeout_seconds register width
  localparam int unsigned RPM_W     = 16;  // result width, also quotient bits
  localparam int unsigned NUM_W     = CLK_W + 5;       // 30 * clock_hz
  localparam int unsigned PROD_W    = CLK_W + TMO_W;   // timeout_seconds * clock_hz
  localparam int unsigned STEP_W    = $clog2(RPM_W);
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CLK_W-1:0] CLOCK_HZ_RST = CLK_W'(64000000);
  localparam logic [TMO_W-1:0] TIMEOUT_RST  = TMO_W'(1);
  localparam logic [RPM_W-1:0] RPM_MAX      = {RPM_W{1'b1}};

  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } fantach_div_stat_t;

endpackage

>>> hw/rtl/fantach_divider.sv
// Saturating restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module fantach_divider
  import fantach_pkg::*;
#(
  parameter int unsigned DEN_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  numer_i,
  input  logic [DEN_W-1:0]  denom_i,
  output fantach_div_stat_t stat_o,
  output logic [RPM_W-1:0]  quot_o
);

  localparam int unsigned CMP_W = (DEN_W + RPM_W > NUM_W) ? DEN_W + RPM_W : NUM_W;

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [DEN_W:0]    rem_q;
  logic [RPM_W-1:0]  quo_q;
  logic [RPM_W-1:0]  lo_q;
  logic [DEN_W-1:0]  den_q;

  logic [CMP_W-1:0]  numer_ext;
  logic [CMP_W-1:0]  den_ext;
  logic [CMP_W-1:0]  numer_hi;
  logic              sat;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W+1:0]  diff;
  logic              qbit;

  // Quotient cannot fit the result when numer >= denom * 2^16; covers denom zero.
  assign numer_ext = CMP_W'(numer_i);
  assign den_ext   = CMP_W'({denom_i, {RPM_W{1'b0}}});
  assign sat       = (numer_ext >= den_ext);
  assign numer_hi  = numer_ext >> RPM_W;

  assign rem_sh = {rem_q[DEN_W-1:0], lo_q[cnt_q]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign qbit   = ~diff[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      lo_q   <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (sat) begin
          quo_q  <= RPM_MAX;
          done_q <= 1'b1;
        end else begin
          // Not saturated, so the high part is already below the divisor.
          rem_q  <= numer_hi[DEN_W:0];
          lo_q   <= numer_i[RPM_W-1:0];
          den_q  <= denom_i;
          quo_q  <= '0;
          cnt_q  <= STEP_W'(RPM_W - 1);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (qbit) begin
          rem_q <= diff[DEN_W:0];
        end else begin
          rem_q <= rem_sh;
        end
        quo_q <= {quo_q[RPM_W-2:0], qbit};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

>>> hw/rtl/fan_tachometer_rpm_core.sv
// Top level of the fan tachometer speed meter.
// Each item is a tach edge or a timeout check stamped with a free-running cycle count.
// An edge sets rpm = floor(30 * clock_hz / delta), saturated to 65535 (also for a zero
// delta), and makes its timestamp the new reference; a timeout check clears rpm once
// delta >= timeout_seconds * clock_hz. Every item returns one rpm value. An edge's result
// is set by the 16 subtract-compare steps of the divider, which are skipped when the
// quotient saturates at the start; a timeout check's result takes one registered 8x32
// product of timeout_seconds and clock_hz and one compare.
// in_ready_o is low while an item is in work and rises on the clock edge on which the result is
// loaded; the result sits in an output register, so the next item may be taken before
// it is read.
`timescale 1ns / 1ps
`include "fan_tachometer_rpm_core_assert.svh"
module fan_tachometer_rpm_core
  import fantach_pkg::*;
#(
  parameter int unsigned TIMESTAMP_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CLK_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [TS_IN_W-1:0]   timestamp_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [RPM_W-1:0]     rpm_o
);

  localparam int unsigned DELTA_W = (TIMESTAMP_WIDTH < TS_IN_W) ? TIMESTAMP_WIDTH : TS_IN_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CMP,
    ST_FIN
  } state_e;

  state_e             state_q;
  logic               op_q;
  logic [DELTA_W-1:0] ts_q;
  logic [DELTA_W-1:0] last_q;
  logic [DELTA_W-1:0] delta_q;
  logic [PROD_W-1:0]  prod_q;
  logic [RPM_W-1:0]   speed_q;
  logic               out_valid_q;
  logic [RPM_W-1:0]   out_rpm_q;
  logic [CLK_W-1:0]   clock_hz_q;
  logic [TMO_W-1:0]   timeout_q;

  logic               in_fire;
  logic               div_start;
  logic [NUM_W-1:0]   numer;
  logic [PROD_W-1:0]  prod_d;
  fantach_div_stat_t  div_stat;
  logic [RPM_W-1:0]   div_quot;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= CLOCK_HZ_RST;
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CLOCK_HZ: clock_hz_q <= cfg_data_i;
        CFG_TIMEOUT:  timeout_q  <= cfg_data_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign div_start  = (state_q == ST_DIV_START);

  // 30 * clock_hz as 32x - 2x
  assign numer  = (NUM_W'(clock_hz_q) << 5) - (NUM_W'(clock_hz_q) << 1);
  assign prod_d = PROD_W'(timeout_q) * PROD_W'(clock_hz_q);

  fantach_divider #(
    .DEN_W (DELTA_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (numer),
    .denom_i (delta_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_EDGE;
      ts_q        <= '0;
      last_q      <= '0;
      delta_q     <= '0;
      prod_q      <= '0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
      out_rpm_q   <= '0;
    end else begin
      // Drop the held result once read; the finish state reloads it itself.
      if (out_valid_q && out_ready_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            op_q    <= operation_i;
            ts_q    <= timestamp_i[DELTA_W-1:0];
            state_q <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          delta_q <= ts_q - last_q;
          prod_q  <= prod_d;
          state_q <= (op_q == OP_EDGE) ? ST_DIV_START : ST_CMP;
        end
        ST_DIV_START: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            speed_q <= div_quot;
            last_q  <= ts_q;
            state_q <= ST_FIN;
          end
        end
        ST_CMP: begin
          if (PROD_W'(delta_q) >= prod_q) begin
            speed_q <= '0;
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          // Hold until the output register is free or being drained.
          if (!out_valid_q || out_ready_i) begin
            out_rpm_q   <= speed_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign rpm_o       = out_rpm_q;

  `FANTACH_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready_o, "ready high after accept")
  `FANTACH_ASSERT_NOW(a_div_only_in_wait, div_stat.busy || div_stat.done, state_q == ST_DIV_WAIT, "divider active outside wait")
  `FANTACH_ASSERT_NEXT(a_timeout_keeps_ref, state_q == ST_CMP, $stable(last_q), "timeout check moved edge reference")

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the fan tachometer rpm core.
`timescale 1ns / 1ps
module tb_top;
  import fantach_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 40;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CLK_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready_o;
  logic                 operation;
  logic [TS_IN_W-1:0]   timestamp;
  logic                 out_valid_o;
  logic                 out_ready = 1'b0;
  logic [RPM_W-1:0]     rpm_o;

  // Shadow copy of the speed meter.
  logic [CLK_W-1:0]   hz_setting;
  logic [TMO_W-1:0]   tmo_setting;
  logic [TS_IN_W-1:0] pred_edge_stamp;
  logic [RPM_W-1:0]   pred_speed;

  logic [RPM_W-1:0] rpm_expected_q[$];
  int unsigned      error_count = 0;
  bit               calm;
  bit               idle_on;
  int unsigned      stall_left = 0;

  fan_tachometer_rpm_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .operation_i (operation),
    .timestamp_i (timestamp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .rpm_o       (rpm_o)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [RPM_W-1:0] predict_rpm(logic op, logic [TS_IN_W-1:0] ts);
    logic [TS_IN_W-1:0] delta;
    logic [63:0]        quot;
    logic [63:0]        trip;
    delta = ts - pred_edge_stamp;
    if (op == OP_EDGE) begin
      if (delta == '0) begin
        pred_speed = RPM_MAX;
      end else begin
        quot = (64'd30 * {32'd0, hz_setting}) / {32'd0, delta};
        pred_speed = (quot > {48'd0, RPM_MAX}) ? RPM_MAX : quot[RPM_W-1:0];
      end
      pred_edge_stamp = ts;
    end else begin
      trip = {56'd0, tmo_setting} * {32'd0, hz_setting};
      if ({32'd0, delta} >= trip) pred_speed = '0;
    end
    return pred_speed;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_event(input logic op, input logic [TS_IN_W-1:0] ts);
    if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    timestamp <= ts;
    do @(posedge clk); while (!in_ready_o);
    rpm_expected_q.push_back(predict_rpm(op, ts));
  endtask

  task automatic send_after(input logic op, input logic [TS_IN_W-1:0] gap);
    send_event(op, pred_edge_stamp + gap);
  endtask

  // Hold off until every result is back and the core has gone quiet.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (rpm_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CLK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CFG_CLOCK_HZ) hz_setting = data;
    else tmo_setting = data[TMO_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_speed_config(input logic [CLK_W-1:0] hz, input logic [TMO_W-1:0] tmo);
    wait_results_drained();
    write_register(CFG_CLOCK_HZ, hz);
    // upper data bits are don't-care for the timeout register
    write_register(CFG_TIMEOUT, {24'($urandom), tmo});
  endtask

  task automatic send_random_event();
    int unsigned        pick;
    logic [63:0]        span;
    logic [63:0]        trip;
    logic [TS_IN_W-1:0] gap;
    pick = $urandom_range(0, 99);
    span = 64'd30 * {32'd0, hz_setting};
    trip = {56'd0, tmo_setting} * {32'd0, hz_setting};
    if (pick < 60) begin
      // aim at a random speed, sometimes beyond saturation
      span = span / 64'($urandom_range(1, 32'h1FFFF));
      if (span > 64'hFFFF_FFFF) gap = $urandom;
      else gap = span[31:0] + 32'($urandom_range(0, 2));
      send_after(OP_EDGE, gap);
    end else if (pick < 63) begin
      send_after(OP_EDGE, '0);
    end else if (pick < 75) begin
      send_event(OP_EDGE, $urandom);
    end else if (pick < 90 && trip <= 64'hFFFF_FFFF) begin
      // straddle the timeout threshold
      if (trip < 64'd2) gap = 32'($urandom_range(0, 2));
      else gap = trip[31:0] - 32'd2 + 32'($urandom_range(0, 4));
      send_after(OP_TIMEOUT, gap);
    end else if (pick < 95) begin
      send_after(OP_TIMEOUT, 32'($urandom_range(0, 100000)));
    end else begin
      send_after(OP_TIMEOUT, $urandom);
    end
  endtask

  task automatic test_reset_defaults();
    send_event(OP_EDGE, 32'd0);
    send_event(OP_EDGE, 32'd1920000000);
    send_after(OP_TIMEOUT, 32'd63999999);
    send_after(OP_TIMEOUT, 32'd64000000);
    send_after(OP_EDGE, 32'd29297);
    send_after(OP_EDGE, 32'd29298);
    send_event(OP_EDGE, 32'hFFFF_FFFF);
    send_event(OP_EDGE, 32'h0000_1000);
    send_event(OP_TIMEOUT, 32'hFFFF_FFFF);
    send_after(OP_EDGE, 32'd1);
  endtask

  task automatic test_config_extremes();
    // zero clock rate: edges read zero but a zero delta saturates, a check always clears
    set_speed_config('0, 8'd1);
    send_after(OP_EDGE, 32'd100);
    send_after(OP_EDGE, '0);
    send_after(OP_TIMEOUT, '0);
    // zero timeout always clears
    set_speed_config(CLOCK_HZ_RST, 8'd0);
    send_after(OP_EDGE, 32'd30000);
    send_after(OP_TIMEOUT, '0);
    set_speed_config(32'hFFFF_FFFF, 8'd255);
    send_after(OP_EDGE, 32'hFFFF_FFFF);
    send_after(OP_EDGE, 32'd2000000);
    send_after(OP_TIMEOUT, 32'hFFFF_FFFF);
    set_speed_config(32'd1, 8'd1);
    send_after(OP_EDGE, 32'd30);
    send_after(OP_EDGE, 32'd31);
    send_after(OP_EDGE, 32'd1);
    send_after(OP_TIMEOUT, 32'd1);
  endtask

  task automatic test_random_sweep();
    logic [CLK_W-1:0] hz;
    logic [TMO_W-1:0] tmo;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 3))
        0: hz = 32'($urandom_range(1000000, 200000000));
        1: hz = $urandom;
        2: hz = 32'($urandom_range(1, 5000));
        default: hz = CLOCK_HZ_RST;
      endcase
      tmo = 8'($urandom_range(1, 255));
      if (phase == 0) begin
        hz  = 32'hFFFF_FFFF;
        tmo = 8'd255;
      end else if (phase == 1) begin
        hz  = 32'd1;
        tmo = 8'd1;
      end
      set_speed_config(hz, tmo);
      idle_on = (phase != 3);
      for (int n = 0; n < 160; n++) send_random_event();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_steady_drain();
    set_speed_config(CLOCK_HZ_RST, TIMEOUT_RST);
    calm = 1'b1;
    for (int n = 0; n < 100; n++) send_random_event();
  endtask

  // Receiver side: stall in random bursts unless calm is set.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && out_ready) begin
      if (rpm_expected_q.size() == 0) begin
        report_mismatch($sformatf("result rpm=%0d with no item outstanding", rpm_o));
      end else if (rpm_o !== rpm_expected_q[0]) begin
        report_mismatch($sformatf("rpm got %0d, want %0d", rpm_o, rpm_expected_q[0]));
        void'(rpm_expected_q.pop_front());
      end else begin
        void'(rpm_expected_q.pop_front());
      end
    end
  end

  initial begin
    int unsigned stuck;
    stuck = 0;
    @(posedge rst_n);
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
          (cfg_valid && cfg_ready_o)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_CLOCK_HZ;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    operation  <= OP_EDGE;
    timestamp  <= '0;
    calm        = 1'b0;
    idle_on     = 1'b1;
    hz_setting      = CLOCK_HZ_RST;
    tmo_setting     = TIMEOUT_RST;
    pred_edge_stamp = '0;
    pred_speed      = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_config_extremes();
    test_random_sweep();
    test_steady_drain();

    in_valid <= 1'b0;
    while (rpm_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
